// ===== rtl/core/pnv_pkg.sv =====
package pnv_pkg;

  // field widths
  localparam int PixelW = 16;
  localparam int ValueW = 15;
  localparam int CountW = 16;
  localparam int GainW  = 32;
  localparam int CfgW   = 32;
  localparam int CfgIdxW = 3;

  // default marker for masked pixels
  localparam int MarkerDefault = 32767;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_HIGH_CLIP      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_CLIP       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INV_GAIN       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_READ_VAR       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FIRST_GOOD_ROW = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_END_GOOD_ROW   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FIRST_GOOD_COL = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_END_GOOD_COL   = 3'd7;

  // product of a positive pixel and the inverse gain
  localparam int ProdW = (PixelW - 1) + GainW;
  localparam int AccW  = ProdW + 1;

  typedef logic [ValueW-1:0] value_t;

endpackage

// ===== rtl/core/pixel_noise_variance_map.sv =====
// channel   | ports                                              | direction
// ----------+----------------------------------------------------+----------
// pixels    | in_valid/in_ready, in_pixel, in_last_in_row,       | in
//           | in_last_in_frame                                   |
// variance  | out_valid/out_ready, out_noise_value, out_masked,  | out
//           | out_row_end, out_frame_end                         |
// config    | cfg_we, cfg_index, cfg_data                        | in
//
// One pixel per clock while the output is not stalled; two register stages:
// a pixel is registered in the first stage, then in the output stage, which
// drives out_valid. The first stage does the position/clip compares and the
// 15x32 multiply; the second adds the read variance, truncates and saturates.
// Reset (synchronous, active low) empties both stages, zeroes the row and
// column counters and loads the register defaults.
// A stalled output holds; the first stage keeps taking pixels until it too
// is full, so in_ready drops only when both stages hold data.
module pixel_noise_variance_map
  import pnv_pkg::*;
#(
  parameter int MARKER_VALUE = MarkerDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // pixel input
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [PixelW-1:0]  in_pixel,
  input  logic                      in_last_in_row,
  input  logic                      in_last_in_frame,
  // variance output
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ValueW-1:0]         out_noise_value,
  output logic                      out_masked,
  output logic                      out_row_end,
  output logic                      out_frame_end,
  // configuration writes
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgW-1:0]           cfg_data
);

  localparam logic [ValueW-1:0] Marker   = ValueW'(MARKER_VALUE);
  localparam logic [ValueW-1:0] SatLimit = ValueW'(MARKER_VALUE - 1);

  // configuration registers
  logic signed [PixelW-1:0] high_clip_r;
  logic signed [PixelW-1:0] low_clip_r;
  logic [GainW-1:0]         inv_gain_r;
  logic [GainW-1:0]         read_var_r;
  logic [CountW-1:0]        first_good_row_r;
  logic [CountW-1:0]        end_good_row_r;
  logic [CountW-1:0]        first_good_col_r;
  logic [CountW-1:0]        end_good_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_clip_r      <= 16'sh7fff;
      low_clip_r       <= 16'sh8000;
      inv_gain_r       <= 32'h0001_0000;
      read_var_r       <= '0;
      first_good_row_r <= '0;
      end_good_row_r   <= '1;
      first_good_col_r <= '0;
      end_good_col_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_CLIP:      high_clip_r      <= cfg_data[PixelW-1:0];
        REG_LOW_CLIP:       low_clip_r       <= cfg_data[PixelW-1:0];
        REG_INV_GAIN:       inv_gain_r       <= cfg_data[GainW-1:0];
        REG_READ_VAR:       read_var_r       <= cfg_data[GainW-1:0];
        REG_FIRST_GOOD_ROW: first_good_row_r <= cfg_data[CountW-1:0];
        REG_END_GOOD_ROW:   end_good_row_r   <= cfg_data[CountW-1:0];
        REG_FIRST_GOOD_COL: first_good_col_r <= cfg_data[CountW-1:0];
        REG_END_GOOD_COL:   end_good_col_r   <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic a_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic a_adv;
  logic in_xfer;

  assign out_adv  = !out_valid_r || out_ready;
  assign a_adv    = !a_valid_r || out_adv;
  assign in_ready = a_adv;
  assign in_xfer  = in_valid && a_adv;

  // position counters
  logic [CountW-1:0] col_count_r;
  logic [CountW-1:0] row_count_r;
  logic [CountW-1:0] col_count_nxt;
  logic [CountW-1:0] row_count_nxt;

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (in_last_in_frame) begin
      col_count_nxt = '0;
      row_count_nxt = '0;
    end else if (in_last_in_row) begin
      col_count_nxt = '0;
      if (row_count_r != '1) row_count_nxt = row_count_r + 1'b1;
    end else if (col_count_r != '1) begin
      col_count_nxt = col_count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_xfer) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // stage a: mask decision and shot-noise product
  logic             bad_row;
  logic             bad_col;
  logic             clipped;
  logic             px_pos;
  logic [PixelW-2:0] px_mag;
  logic [ProdW-1:0] prod_nxt;

  assign bad_row = (row_count_r < first_good_row_r) || (row_count_r >= end_good_row_r);
  assign bad_col = (col_count_r < first_good_col_r) || (col_count_r >= end_good_col_r);
  assign clipped = (in_pixel >= high_clip_r) || (in_pixel <= low_clip_r);
  assign px_pos  = !in_pixel[PixelW-1] && (in_pixel != '0);
  assign px_mag  = px_pos ? in_pixel[PixelW-2:0] : '0;
  assign prod_nxt = ProdW'(px_mag) * ProdW'(inv_gain_r);

  logic [ProdW-1:0] a_prod_r;
  logic             a_masked_r;
  logic             a_row_end_r;
  logic             a_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_prod_r      <= prod_nxt;
      a_masked_r    <= bad_row || bad_col || clipped;
      a_row_end_r   <= in_last_in_row;
      a_frame_end_r <= in_last_in_frame;
    end
  end

  // stage b: add read variance, truncate, saturate
  logic [AccW-1:0]       acc;
  logic [AccW-17:0]      acc_int;
  logic [ValueW-1:0]     value_nxt;

  assign acc     = AccW'(a_prod_r) + AccW'(read_var_r);
  assign acc_int = acc[AccW-1:16];

  always_comb begin
    if (a_masked_r) begin
      value_nxt = Marker;
    end else if (acc_int > (AccW-16)'(SatLimit)) begin
      value_nxt = SatLimit;
    end else begin
      value_nxt = acc_int[ValueW-1:0];
    end
  end

  value_t out_value_r;
  logic   out_masked_r;
  logic   out_row_end_r;
  logic   out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid_r) begin
      out_value_r     <= value_nxt;
      out_masked_r    <= a_masked_r;
      out_row_end_r   <= a_row_end_r;
      out_frame_end_r <= a_frame_end_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;
  assign out_masked      = out_masked_r;
  assign out_row_end     = out_row_end_r;
  assign out_frame_end   = out_frame_end_r;

endmodule

// ===== rtl/core/pnv_checker.sv =====
module pnv_checker
  import pnv_pkg::*;
#(
  parameter int MARKER_VALUE = MarkerDefault
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic signed [PixelW-1:0] in_pixel,
  input logic                     in_last_in_row,
  input logic                     in_last_in_frame,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ValueW-1:0]        out_noise_value,
  input logic                     out_masked,
  input logic                     out_row_end,
  input logic                     out_frame_end
);

  localparam logic [ValueW-1:0] Marker = ValueW'(MARKER_VALUE);

  // waiting pixel holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_pixel)
      && $stable(in_last_in_row) && $stable(in_last_in_frame))
    else $error("waiting input changed");

  // stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value)
      && $stable(out_masked) && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled output changed");

  // marker value and masked flag go together
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_masked == (out_noise_value == Marker)))
    else $error("marker and masked flag disagree");

  // an empty output stage never blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // no result appears right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind pixel_noise_variance_map pnv_checker #(.MARKER_VALUE(MARKER_VALUE)) u_pnv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_pixel         (in_pixel),
  .in_last_in_row   (in_last_in_row),
  .in_last_in_frame (in_last_in_frame),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_noise_value  (out_noise_value),
  .out_masked       (out_masked),
  .out_row_end      (out_row_end),
  .out_frame_end    (out_frame_end)
);

// ===== sim/pixel_noise_variance_map_tb.sv =====
`timescale 1ns / 1ps

module pixel_noise_variance_map_tb;
  import pnv_pkg::*;

  localparam int Marker      = MarkerDefault;
  localparam int ValueMax    = Marker - 1;
  // two pipeline stages, plus margin
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [ValueW-1:0] noise_value;
    logic              masked;
    logic              row_end;
    logic              frame_end;
  } variance_t;

  typedef struct {
    logic signed [PixelW-1:0] high_clip;
    logic signed [PixelW-1:0] low_clip;
    logic [GainW-1:0]         inv_gain;
    logic [CfgW-1:0]          read_var;
    logic [CountW-1:0]        first_row;
    logic [CountW-1:0]        end_row;
    logic [CountW-1:0]        first_col;
    logic [CountW-1:0]        end_col;
  } settings_t;

  logic                     clk              = 1'b0;
  logic                     rst_n            = 1'b0;
  logic                     in_valid         = 1'b0;
  logic                     in_ready;
  logic signed [PixelW-1:0] in_pixel         = '0;
  logic                     in_last_in_row   = 1'b0;
  logic                     in_last_in_frame = 1'b0;
  logic                     out_valid;
  logic                     out_ready        = 1'b0;
  logic [ValueW-1:0]        out_noise_value;
  logic                     out_masked;
  logic                     out_row_end;
  logic                     out_frame_end;
  logic                     cfg_we           = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index        = '0;
  logic [CfgW-1:0]          cfg_data         = '0;

  // predictor copy of the registers and the position counters
  settings_t         cur;
  logic [CountW-1:0] col_pos;
  logic [CountW-1:0] row_pos;
  variance_t         variance_q[$];

  int unsigned err_count     = 0;
  bit          in_gaps_en    = 1'b1;
  bit          out_stalls_en = 1'b1;
  int unsigned hold_req      = 0;
  int unsigned stall_left    = 0;
  int unsigned free_left     = 0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_noise_variance_map #(
    .MARKER_VALUE(Marker)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .in_last_in_row   (in_last_in_row),
    .in_last_in_frame (in_last_in_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_noise_value  (out_noise_value),
    .out_masked       (out_masked),
    .out_row_end      (out_row_end),
    .out_frame_end    (out_frame_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic settings_t default_settings();
    settings_t s;
    s.high_clip = 16'sh7FFF;
    s.low_clip  = 16'sh8000;
    s.inv_gain  = 32'h0001_0000;
    s.read_var  = '0;
    s.first_row = '0;
    s.end_row   = '1;
    s.first_col = '0;
    s.end_col   = '1;
    return s;
  endfunction

  // expected variance of one pixel, then advance the position
  task automatic predict_pixel(input logic signed [PixelW-1:0] px, input logic lr,
                               input logic lf);
    variance_t   r;
    logic [63:0] acc;
    logic [63:0] whole;
    bit          bad_row;
    bit          bad_col;
    bit          clipped;
    bad_row = (row_pos < cur.first_row) || (row_pos >= cur.end_row);
    bad_col = (col_pos < cur.first_col) || (col_pos >= cur.end_col);
    clipped = (px >= cur.high_clip) || (px <= cur.low_clip);
    if (bad_row || bad_col || clipped) begin
      r.noise_value = ValueW'(Marker);
      r.masked      = 1'b1;
    end else begin
      acc = 64'(cur.read_var);
      if (px > 0) acc = acc + 64'(px[PixelW-2:0]) * 64'(cur.inv_gain);
      whole = acc >> 16;
      if (whole > 64'(ValueMax)) whole = 64'(ValueMax);
      r.noise_value = whole[ValueW-1:0];
      r.masked      = 1'b0;
    end
    r.row_end   = lr;
    r.frame_end = lf;
    variance_q.push_back(r);
    // counters saturate, frame end wins over row end
    if (lf) begin
      col_pos = '0;
      row_pos = '0;
    end else if (lr) begin
      col_pos = '0;
      if (row_pos != '1) row_pos = row_pos + 1'b1;
    end else if (col_pos != '1) begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  // one pixel transfer, then an optional gap
  task automatic send_pixel(input logic signed [PixelW-1:0] px, input logic lr,
                            input logic lf);
    int unsigned gap;
    in_valid         <= 1'b1;
    in_pixel         <= px;
    in_last_in_row   <= lr;
    in_last_in_frame <= lf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(px, lr, lf);
    gap = in_gaps_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (variance_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // all eight registers; upper bits of the narrow ones carry junk
  task automatic load_settings(input settings_t s);
    write_reg(REG_HIGH_CLIP,      {16'($urandom), s.high_clip});
    write_reg(REG_LOW_CLIP,       {16'($urandom), s.low_clip});
    write_reg(REG_INV_GAIN,       s.inv_gain);
    write_reg(REG_READ_VAR,       s.read_var);
    write_reg(REG_FIRST_GOOD_ROW, {16'($urandom), s.first_row});
    write_reg(REG_END_GOOD_ROW,   {16'($urandom), s.end_row});
    write_reg(REG_FIRST_GOOD_COL, {16'($urandom), s.first_col});
    write_reg(REG_END_GOOD_COL,   {16'($urandom), s.end_col});
    cfg_we <= 1'b0;
    cur = s;
  endtask

  function automatic logic [CountW-1:0] rand_bound(input int unsigned roll,
                                                   input bit is_end);
    case (roll)
      0:       return is_end ? '1 : '0;
      1:       return is_end ? CountW'($urandom_range(12)) : CountW'($urandom_range(3));
      2:       return is_end ? '0 : '1;
      default: return CountW'($urandom);
    endcase
  endfunction

  function automatic settings_t rand_settings();
    settings_t   s;
    int unsigned roll;
    roll = $urandom_range(3);
    if (roll == 0) begin
      s.high_clip = 16'sh7FFF;
      s.low_clip  = 16'sh8000;
    end else if (roll == 3) begin
      s.high_clip = 16'($urandom);
      s.low_clip  = 16'($urandom);
    end else begin
      s.high_clip = 16'($urandom_range(32767, 500));
      s.low_clip  = -16'($urandom_range(32768, 0));
    end
    case ($urandom_range(4))
      0:       s.inv_gain = '0;
      1:       s.inv_gain = '1;
      2:       s.inv_gain = $urandom;
      default: s.inv_gain = $urandom_range(32'h0002_0000, 32'h0000_1000);
    endcase
    case ($urandom_range(4))
      0:       s.read_var = '0;
      1:       s.read_var = '1;
      2:       s.read_var = $urandom;
      default: s.read_var = $urandom_range(200 << 16, 0);
    endcase
    // mostly small windows so borders fall inside short frames
    roll = ($urandom_range(2) == 0) ? $urandom_range(3) : 1;
    s.first_row = rand_bound(roll, 1'b0);
    s.end_row   = rand_bound(roll, 1'b1);
    roll = ($urandom_range(2) == 0) ? $urandom_range(3) : 1;
    s.first_col = rand_bound(roll, 1'b0);
    s.end_col   = rand_bound(roll, 1'b1);
    return s;
  endfunction

  function automatic logic signed [PixelW-1:0] rand_pixel();
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return cur.high_clip + 16'($urandom_range(2)) - 16'd1;
      2:       return cur.low_clip + 16'($urandom_range(2)) - 16'd1;
      3:       return 16'($urandom_range(400));
      4:       return -16'($urandom_range(400));
      default: begin
        case ($urandom_range(3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'sh0001;
        endcase
      end
    endcase
  endfunction

  // receiver: random stalls, and a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != 0) begin
      stall_left = hold_req - 1;
      hold_req   = 0;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (free_left != 0) begin
      free_left = free_left - 1;
      out_ready <= 1'b1;
    end else if (!out_stalls_en || $urandom_range(2) != 0) begin
      free_left = out_stalls_en ? $urandom_range(15) : 0;
      out_ready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_variance
    variance_t want;
    if (rst_n && out_valid && out_ready) begin
      if (variance_q.size() == 0) begin
        $error("result transfer with no pixel pending");
        err_count++;
      end else begin
        want = variance_q.pop_front();
        if (out_noise_value !== want.noise_value) begin
          $error("noise_value: expected %0d, got %0d", want.noise_value, out_noise_value);
          err_count++;
        end
        if (out_masked !== want.masked) begin
          $error("masked: expected %0b, got %0b", want.masked, out_masked);
          err_count++;
        end
        if (out_row_end !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, out_row_end);
          err_count++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
          err_count++;
        end
      end
    end
  end

  // register defaults after reset, clip edges at full range
  task automatic test_reset_defaults();
    send_pixel(16'sd0, 1'b0, 1'b0);
    send_pixel(-16'sd1, 1'b0, 1'b0);
    send_pixel(16'sd32766, 1'b0, 1'b0);
    send_pixel(16'sh7FFF, 1'b1, 1'b0);
    send_pixel(16'sh8000, 1'b0, 1'b0);
    send_pixel(16'sd1234, 1'b1, 1'b1);
    wait_idle();
  endtask

  // saturation, truncation, non-positive pixels and clip boundaries
  task automatic test_arith_limits();
    settings_t s;
    s = default_settings();
    s.read_var = '1;
    s.inv_gain = '1;
    load_settings(s);
    send_pixel(16'sd32766, 1'b0, 1'b0);
    send_pixel(-16'sd5, 1'b0, 1'b0);
    wait_idle();
    s.read_var = 32'h0001_8000;
    s.inv_gain = '0;
    load_settings(s);
    send_pixel(16'sd100, 1'b0, 1'b0);
    send_pixel(16'sd0, 1'b0, 1'b0);
    wait_idle();
    s.read_var = {16'd32766, 16'hFFFF};
    load_settings(s);
    send_pixel(16'sd7, 1'b0, 1'b0);
    wait_idle();
    s = default_settings();
    s.high_clip = 16'sd100;
    s.low_clip  = -16'sd100;
    load_settings(s);
    send_pixel(16'sd99, 1'b0, 1'b0);
    send_pixel(16'sd100, 1'b0, 1'b0);
    send_pixel(-16'sd99, 1'b0, 1'b0);
    send_pixel(-16'sd100, 1'b0, 1'b0);
    wait_idle();
    // inverted clip range masks everything
    s.high_clip = 16'sh8000;
    s.low_clip  = 16'sh7FFF;
    load_settings(s);
    send_pixel(16'sd0, 1'b1, 1'b1);
    wait_idle();
  endtask

  // border rows and columns, frame end in mid row, empty window
  task automatic test_window();
    settings_t s;
    s = default_settings();
    s.first_row = 16'd1;
    s.end_row   = 16'd3;
    s.first_col = 16'd1;
    s.end_col   = 16'd3;
    load_settings(s);
    send_pixel(16'sd10, 1'b0, 1'b0);
    send_pixel(16'sd11, 1'b0, 1'b0);
    send_pixel(16'sd12, 1'b1, 1'b0);
    send_pixel(16'sd20, 1'b0, 1'b0);
    send_pixel(16'sd21, 1'b0, 1'b0);
    send_pixel(16'sd22, 1'b1, 1'b0);
    send_pixel(16'sd30, 1'b0, 1'b0);
    send_pixel(16'sd31, 1'b0, 1'b1);
    send_pixel(16'sd40, 1'b1, 1'b1);
    wait_idle();
    s = default_settings();
    s.first_col = 16'd0;
    s.end_col   = 16'd0;
    load_settings(s);
    send_pixel(16'sd50, 1'b0, 1'b0);
    send_pixel(16'sd51, 1'b1, 1'b1);
    wait_idle();
  endtask

  // one long row with a column window in its middle
  task automatic test_long_row();
    settings_t s;
    s = default_settings();
    s.first_col = 16'd3;
    s.end_col   = 16'd180;
    load_settings(s);
    repeat (199) send_pixel(rand_pixel(), 1'b0, 1'b0);
    send_pixel(rand_pixel(), 1'b1, 1'b1);
    wait_idle();
  endtask

  // long receiver hold while pixels keep coming
  task automatic test_backpressure();
    in_gaps_en    = 1'b0;
    out_stalls_en = 1'b0;
    load_settings(rand_settings());
    hold_req = 200;
    repeat (39) send_pixel(rand_pixel(), 1'b0, 1'b0);
    send_pixel(rand_pixel(), 1'b1, 1'b1);
    wait_idle();
    in_gaps_en    = 1'b1;
    out_stalls_en = 1'b1;
  endtask

  // mostly well-formed frames, some stray marks
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    logic        lr;
    logic        lf;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(5, 1)) begin
          send_pixel(rand_pixel(), 1'($urandom), 1'($urandom));
          sent++;
        end
      end else begin
        w = $urandom_range(12, 1);
        h = $urandom_range(6, 1);
        for (int r = 0; r < h; r++) begin
          for (int c = 0; c < w; c++) begin
            lr = (c == w - 1);
            lf = (r == h - 1) && (c == w - 1);
            if (lf && $urandom_range(3) == 0) lr = 1'b0;
            send_pixel(rand_pixel(), lr, lf);
            sent++;
          end
        end
      end
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      in_gaps_en    = (p == 0) ? 1'b0 : ($urandom_range(3) != 0);
      out_stalls_en = (p == 0) ? 1'b0 : ($urandom_range(3) != 0);
      load_settings(rand_settings());
      run_random_phase(110);
      wait_idle();
    end
  endtask

  initial begin : main_flow
    cur     = default_settings();
    col_pos = '0;
    row_pos = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_arith_limits();
    test_window();
    test_long_row();
    test_backpressure();
    test_random();
    wait_idle();
    if (err_count == 0) begin
      $display("pixel_noise_variance_map_tb OK");
    end else begin
      $display("pixel_noise_variance_map_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(20_000_000);
    $display("pixel_noise_variance_map_tb NOT OK");
    $finish;
  end

endmodule
